>>> design/tmps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tmps_pkg;

   localparam int MAX_ROWS_DEF    = 256;
   localparam int VALUE_WIDTH_DEF = 16;
   localparam int ROW_COUNT_W     = 9;
   localparam int SUM_W           = 24;

   localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RESET = ROW_COUNT_W'(1);
   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   // position of one element within the triangle
   typedef struct packed {
      logic first_row;
      logic left_edge;
      logic right_edge;
      logic last_row;
   } tmps_flags_type;

endpackage
`default_nettype wire

>>> design/tmps_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module tmps_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> design/tmps_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
module tmps_sequencer #(
   parameter int MAX_ROWS = 256
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_wen,
   input  wire logic [tmps_pkg::ROW_COUNT_W-1:0]      csr_wdata,
   input  wire logic                                  accept,
   output logic      [$clog2(MAX_ROWS)-1:0]           column,
   output tmps_pkg::tmps_flags_type                   flags
);
   import tmps_pkg::*;

   localparam int IW   = $clog2(MAX_ROWS);
   localparam int CMPW = (IW + 1 > ROW_COUNT_W) ? IW + 1 : ROW_COUNT_W;

   logic [ROW_COUNT_W-1:0] row_count_ff, row_count_in;
   logic [IW-1:0]          row_ff, row_in;
   logic [IW-1:0]          col_ff, col_in;
   logic [CMPW-1:0]        rows_eff;

   always_comb begin
      if (row_count_ff == '0) begin
         rows_eff = CMPW'(1);
      end else if (CMPW'(row_count_ff) > CMPW'(MAX_ROWS)) begin
         rows_eff = CMPW'(MAX_ROWS);
      end else begin
         rows_eff = CMPW'(row_count_ff);
      end
   end

   always_comb begin
      flags.first_row  = (row_ff == '0);
      flags.left_edge  = (col_ff == '0);
      flags.right_edge = (col_ff == row_ff);
      flags.last_row   = (CMPW'(row_ff) + CMPW'(1)) >= rows_eff;
   end

   assign column = col_ff;

   always_comb begin
      row_count_in = csr_wen ? csr_wdata : row_count_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      if (accept) begin
         if (flags.right_edge) begin
            col_in = '0;
            row_in = flags.last_row ? '0 : row_ff + IW'(1);
         end else begin
            col_in = col_ff + IW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= ROW_COUNT_RESET;
         row_ff       <= '0;
         col_ff       <= '0;
      end else begin
         row_count_ff <= row_count_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
      end
   end

`ifndef SYNTHESIS
   a_col_within_row: assert property (@(posedge clock) disable iff (reset)
      col_ff <= row_ff)
      else $error("column past end of row");
`endif

endmodule
`default_nettype wire

>>> design/tmps_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module tmps_datapath #(
   parameter int MAX_ROWS    = 256,
   parameter int VALUE_WIDTH = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 accept,
   input  wire logic signed [VALUE_WIDTH-1:0]        element,
   input  wire logic [$clog2(MAX_ROWS)-1:0]          column,
   input  wire tmps_pkg::tmps_flags_type             flags,
   input  wire logic [tmps_pkg::SUM_W-1:0]           ram_rd_data,
   output logic                                      ram_wr_en,
   output logic [$clog2(MAX_ROWS)-1:0]               ram_wr_addr,
   output logic [tmps_pkg::SUM_W-1:0]                ram_wr_data,
   output logic                                      in_ready,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [tmps_pkg::SUM_W-1:0]                rsp_tdata   // min_total
);
   import tmps_pkg::*;

   localparam int IW = $clog2(MAX_ROWS);
   localparam int SW = ((VALUE_WIDTH > SUM_W) ? VALUE_WIDTH : SUM_W) + 1;
   localparam logic signed [SW-1:0] HI = SW'(SUM_MAX);
   localparam logic signed [SW-1:0] LO = SW'(SUM_MIN);

   logic                          s_valid_ff, s_valid_in;
   logic signed [VALUE_WIDTH-1:0] s_elem_ff;
   logic [IW-1:0]                 s_addr_ff;
   tmps_flags_type                s_flags_ff;
   logic                          byp_ff, byp_in;
   logic signed [SUM_W-1:0]       byp_data_ff;
   logic signed [SUM_W-1:0]       ul_ff, ul_in;
   logic signed [SUM_W-1:0]       best_ff, best_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_W-1:0]       rsp_data_ff;

   logic signed [SUM_W-1:0] old_here;
   logic signed [SUM_W-1:0] parent;
   logic signed [SW-1:0]    sum_wide;
   logic signed [SUM_W-1:0] sum;
   logic                    emit;
   logic                    advance;

   assign old_here = byp_ff ? byp_data_ff : $signed(ram_rd_data);

   always_comb begin
      if (s_flags_ff.first_row) begin
         parent = '0;
      end else if (s_flags_ff.left_edge) begin
         parent = old_here;
      end else if (s_flags_ff.right_edge) begin
         parent = ul_ff;
      end else begin
         parent = (ul_ff < old_here) ? ul_ff : old_here;
      end
      sum_wide = SW'(parent) + SW'(s_elem_ff);
      if (sum_wide > HI) begin
         sum = SUM_MAX;
      end else if (sum_wide < LO) begin
         sum = SUM_MIN;
      end else begin
         sum = sum_wide[SUM_W-1:0];
      end
   end

   assign emit     = s_valid_ff && s_flags_ff.right_edge && s_flags_ff.last_row;
   assign advance  = s_valid_ff && !(emit && rsp_valid_ff && !rsp_tready);
   assign in_ready = !s_valid_ff || advance;

   assign ram_wr_en   = advance;
   assign ram_wr_addr = s_addr_ff;
   assign ram_wr_data = sum;

   always_comb begin
      s_valid_in   = accept ? 1'b1 : (advance ? 1'b0 : s_valid_ff);
      byp_in       = accept ? (advance && (s_addr_ff == column)) : byp_ff;
      ul_in        = ul_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (advance) begin
         ul_in = s_flags_ff.right_edge ? '0 : old_here;
         if (s_flags_ff.last_row && (s_flags_ff.left_edge || sum < best_ff)) begin
            best_in = sum;
         end
         if (emit) begin
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff   <= 1'b0;
         byp_ff       <= 1'b0;
         ul_ff        <= '0;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s_valid_ff   <= s_valid_in;
         byp_ff       <= byp_in;
         ul_ff        <= ul_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         s_elem_ff   <= element;
         s_addr_ff   <= column;
         s_flags_ff  <= flags;
         byp_data_ff <= sum;
      end
      if (advance && emit) begin
         rsp_data_ff <= best_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_emit_at_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s_flags_ff.right_edge && s_flags_ff.last_row))
      else $error("result raised away from end of triangle");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s_valid_ff && !advance |=> s_valid_ff && $stable(s_addr_ff) && $stable(best_ff))
      else $error("stalled word lost or state moved");
   a_left_addr: assert property (@(posedge clock) disable iff (reset)
      s_valid_ff && s_flags_ff.left_edge |-> s_addr_ff == '0)
      else $error("left edge word not at column zero");
   a_first_row: assert property (@(posedge clock) disable iff (reset)
      s_valid_ff && s_flags_ff.first_row |-> s_flags_ff.left_edge && s_flags_ff.right_edge)
      else $error("top row holds more than one word");
`endif

endmodule
`default_nettype wire

>>> design/triangle_min_path_sum.sv
`timescale 1ns / 1ps
`default_nettype none
// Streams triangle elements row by row (row r has r+1 words) and returns the
// minimum top-to-bottom path sum, saturated to signed 24 bits, one word per
// triangle after its last element. One element is accepted every cycle: the
// row buffer is read as the element is taken and written back from a single
// add/compare stage, with a bypass covering the back-to-back case at the top
// of the triangle. The result is registered when the last element leaves that
// stage; input stalls only if a previous result has not yet been taken when
// the next triangle's last element is ready to finish. Rows per triangle come
// from csr_wdata (0 acts as 1, above MAX_ROWS saturates); write it while idle.
module triangle_min_path_sum #(
   parameter int MAX_ROWS    = tmps_pkg::MAX_ROWS_DEF,
   parameter int VALUE_WIDTH = tmps_pkg::VALUE_WIDTH_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0]       req_tdata,  // element_value
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output logic [tmps_pkg::SUM_W-1:0]                  rsp_tdata,  // min_total
   input  wire logic                                   csr_wen,
   input  wire logic [tmps_pkg::ROW_COUNT_W-1:0]       csr_wdata   // row_count
);
   import tmps_pkg::*;

   localparam int IW = $clog2(MAX_ROWS);

   logic                          accept;
   logic [IW-1:0]                 column;
   tmps_flags_type                flags;
   logic                          ram_wr_en;
   logic [IW-1:0]                 ram_wr_addr;
   logic [SUM_W-1:0]              ram_wr_data;
   logic [SUM_W-1:0]              ram_rd_data;
   logic signed [VALUE_WIDTH-1:0] element;

   assign accept  = req_tvalid && req_tready;
   assign element = $signed(req_tdata[VALUE_WIDTH-1:0]);

   tmps_sequencer #(
      .MAX_ROWS(MAX_ROWS)
   ) u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .csr_wen  (csr_wen),
      .csr_wdata(csr_wdata),
      .accept   (accept),
      .column   (column),
      .flags    (flags)
   );

   tmps_ram #(
      .WIDTH(SUM_W),
      .DEPTH(MAX_ROWS)
   ) u_row_buffer (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (accept),
      .rd_addr(column),
      .rd_data(ram_rd_data)
   );

   tmps_datapath #(
      .MAX_ROWS   (MAX_ROWS),
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .element    (element),
      .column     (column),
      .flags      (flags),
      .ram_rd_data(ram_rd_data),
      .ram_wr_en  (ram_wr_en),
      .ram_wr_addr(ram_wr_addr),
      .ram_wr_data(ram_wr_data),
      .in_ready   (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

>>> verif/tb_triangle_min_path_sum.sv
`timescale 1ns / 1ps
module tb_triangle_min_path_sum;
   import tmps_pkg::*;

   localparam int ROWS_MAX   = MAX_ROWS_DEF;
   localparam int ELEM_W     = VALUE_WIDTH_DEF;
   localparam int DATA_W     = ((VALUE_WIDTH_DEF + 7) / 8) * 8;
   localparam int ITEM_COUNT = 1750;

   class min_path_predictor;
      logic [ROW_COUNT_W-1:0] row_count;
      longint path_sums[ROWS_MAX];
      int row_idx;
      int col_idx;
      longint upper_left;
      longint best;
      longint expected_totals[$];
      int errors;

      function new();
         row_count  = ROW_COUNT_RESET;
         row_idx    = 0;
         col_idx    = 0;
         upper_left = 0;
         best       = 0;
         errors     = 0;
         foreach (path_sums[i]) path_sums[i] = 0;
      endfunction

      function int rows_in_use();
         if (row_count == 0) return 1;
         if (row_count > ROWS_MAX) return ROWS_MAX;
         return int'(row_count);
      endfunction

      function bit at_top();
         return row_idx == 0 && col_idx == 0;
      endfunction

      function int pending();
         return expected_totals.size();
      endfunction

      function void note_element(logic [ELEM_W-1:0] raw);
         longint elem;
         longint old_here;
         longint parent;
         longint total;
         int r;
         int j;
         bit last_row;
         elem     = longint'($signed(raw));
         r        = row_idx % ROWS_MAX;
         j        = col_idx % ROWS_MAX;
         last_row = (r + 1) >= rows_in_use();
         old_here = 0;
         if (j > r) j = r;
         if (j < r) old_here = path_sums[j];
         if (r == 0) parent = 0;
         else if (j == 0) parent = old_here;
         else if (j == r) parent = upper_left;
         else parent = (upper_left < old_here) ? upper_left : old_here;
         total = parent + elem;
         if (total > longint'(SUM_MAX)) total = longint'(SUM_MAX);
         if (total < longint'(SUM_MIN)) total = longint'(SUM_MIN);
         path_sums[j] = total;
         upper_left   = old_here;
         if (last_row && (j == 0 || total < best)) best = total;
         if (j < r) begin
            col_idx = j + 1;
            return;
         end
         col_idx    = 0;
         upper_left = 0;
         if (!last_row) begin
            row_idx = r + 1;
            return;
         end
         row_idx = 0;
         expected_totals.insert(expected_totals.size(), best);
      endfunction

      function void check_total(logic [SUM_W-1:0] got);
         longint want;
         if (expected_totals.size() == 0) begin
            $error("min_total: expected none, actual %0d", $signed(got));
            errors++;
            return;
         end
         want = expected_totals.pop_front();
         if (longint'($signed(got)) != want) begin
            $error("min_total: expected %0d, actual %0d", want, $signed(got));
            errors++;
         end
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [DATA_W-1:0]      req_tdata  = '0;   // element_value
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [SUM_W-1:0]       rsp_tdata;         // min_total
   logic                   csr_wen    = 1'b0;
   logic [ROW_COUNT_W-1:0] csr_wdata  = '0;   // row_count

   min_path_predictor sb;
   bit idle_on   = 1'b0;
   bit long_hold = 1'b0;
   int items_sent;

   triangle_min_path_sum dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      #60000000;
      $display("triangle_min_path_sum verification failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_total(rsp_tdata);
   end

   // receiver: random stalls, plus one long hold on request
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            long_hold = 1'b0;
            rsp_tready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic logic [ELEM_W-1:0] pick_element();
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return ELEM_W'($urandom);
      endcase
   endfunction

   task automatic send_element(input logic [ELEM_W-1:0] value);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= DATA_W'(value);
      do @(posedge clock); while (!req_tready);
      sb.note_element(value);
      items_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_rows(input logic [ROW_COUNT_W-1:0] rows);
      csr_wen   <= 1'b1;
      csr_wdata <= rows;
      @(posedge clock);
      csr_wen <= 1'b0;
      sb.row_count = rows;
   endtask

   task automatic send_triangles(input int count);
      int n;
      n = sb.rows_in_use();
      repeat (count) begin
         if (items_sent < ITEM_COUNT) begin
            repeat (n * (n + 1) / 2) send_element(pick_element());
         end
      end
   endtask

   initial begin
      logic [ROW_COUNT_W-1:0] rows;
      int n;
      int part;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // single-row triangles at reset row count, then zero rows acts as one
      send_element(16'h7FFF);
      send_element(16'h8000);
      send_element(16'h0000);
      send_element(16'hFFFF);
      drain();
      write_rows(0);
      send_element(16'd12345);
      drain();
      write_rows(3);
      send_element(16'd1);
      send_element(16'd2);
      send_element(16'd3);
      send_element(16'h8000);
      send_element(16'h7FFF);
      send_element(16'd4);
      drain();

      // shrink mid-triangle: current row becomes the last one
      write_rows(4);
      send_element(16'd10);
      send_element(-16'sd5);
      send_element(16'd7);
      send_element(16'd3);
      send_element(-16'sd9);
      drain();
      write_rows(2);
      send_element(16'd6);
      drain();

      // grow mid-triangle
      write_rows(2);
      send_element(16'd100);
      drain();
      write_rows(3);
      send_element(-16'sd1);
      send_element(16'd2);
      send_element(-16'sd3);
      send_element(16'd4);
      send_element(-16'sd5);
      drain();

      // row count above max and at max, each cut short by a smaller count
      idle_on = 1'b1;
      write_rows(511);
      repeat (45) send_element(pick_element());
      drain();
      write_rows(2);
      while (!sb.at_top()) send_element(pick_element());
      drain();
      write_rows(256);
      repeat (36) send_element(16'h7FFF);
      drain();
      write_rows(1);
      while (!sb.at_top()) send_element(16'h8000);
      drain();

      // output backpressure fills the block
      write_rows(1);
      long_hold = 1'b1;
      repeat (48) send_element(pick_element());
      drain();

      while (items_sent < ITEM_COUNT) begin
         if (items_sent > ITEM_COUNT - 300) idle_on = 1'b0;
         case ($urandom_range(0, 9))
            0: rows = 0;
            1: rows = ROW_COUNT_W'($urandom_range(9, 24));
            default: rows = ROW_COUNT_W'($urandom_range(1, 8));
         endcase
         write_rows(rows);
         n = sb.rows_in_use();
         if (n >= 2 && $urandom_range(0, 4) == 0) begin
            part = $urandom_range(1, n * (n + 1) / 2 - 1);
            repeat (part) send_element(pick_element());
            drain();
            write_rows(ROW_COUNT_W'($urandom_range(0, 10)));
            while (!sb.at_top()) send_element(pick_element());
         end else begin
            send_triangles($urandom_range(1, 6));
         end
         drain();
      end

      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("triangle_min_path_sum verification clean");
      end else begin
         $display("triangle_min_path_sum verification failed");
      end
      $finish;
   end

endmodule
